// File: hdl/sap_pkg.sv
// Shared types, codes and name constants for the SOCKS address header parser.
package sap_pkg;

  localparam int unsigned TailDepth = 23;

  typedef logic [TailDepth-1:0][7:0] tail_t;  // element 0 is the newest char

  localparam logic [23*8-1:0] NameV2  = "sp.v2.udp-over-tcp.arpa";
  localparam logic [20*8-1:0] NameV1  = "sp.udp-over-tcp.arpa";
  localparam logic [17*8-1:0] NameSfx = "udp-over-tcp.arpa";
  localparam logic [7:0]      LenV2   = 8'd23;
  localparam logic [7:0]      LenV1   = 8'd20;
  localparam logic [7:0]      LenSfx  = 8'd17;

  localparam logic [7:0] TypePlainIpv4   = 8'd1;
  localparam logic [7:0] TypePlainDomain = 8'd3;
  localparam logic [7:0] TypePlainIpv6   = 8'd4;
  localparam logic [7:0] TypePktIpv4     = 8'd0;
  localparam logic [7:0] TypePktIpv6     = 8'd1;
  localparam logic [7:0] TypePktDomain   = 8'd2;

  typedef enum logic [2:0] {
    StBusy     = 3'd0,
    StAddrDone = 3'd1,
    StPktDone  = 3'd2,
    StBadType  = 3'd3,
    StIgnored  = 3'd4
  } status_e;

  typedef enum logic [2:0] {
    RoleType    = 3'd0,
    RoleAddr    = 3'd1,
    RoleDlen    = 3'd2,
    RoleDchar   = 3'd3,
    RolePort    = 3'd4,
    RolePlen    = 3'd5,
    RolePayload = 3'd6,
    RoleNone    = 3'd7
  } role_e;

  typedef enum logic [1:0] {
    KindIpv4   = 2'd0,
    KindIpv6   = 2'd1,
    KindDomain = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    ModeTcp    = 2'd0,
    ModeUotV2  = 2'd1,
    ModeUotV1  = 2'd2,
    ModeUotPkt = 2'd3
  } mode_e;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       frame_start;
  } in_item_t;

  typedef struct packed {
    status_e     status;
    role_e       byte_role;
    logic [7:0]  data_out;
    kind_e       addr_kind;
    logic [15:0] port;
    mode_e       mode;
    logic [8:0]  header_len;
    logic [15:0] pkt_len;
  } out_item_t;

  typedef struct packed {
    logic accept;
    logic packet_mode;
  } step_ctrl_t;

endpackage

// File: hdl/socks_address_header_parser_core.sv
// Top level of the SOCKS address header parser: handshakes, config and result register.
//
// Input channel: one stream byte per request (data_byte, frame_start), taken
// on a clock edge with in_valid_i high and in_stall_o low. frame_start marks
// the type byte of a new message and drops any message in progress.
// Output channel: exactly one result per input byte, in order, presented on
// out_valid_o and taken on an edge where out_stall_i is low.
// out_valid_o is raised in the cycle after acceptance. Throughput is one byte
// per cycle unless the receiver stalls, set by the combinational parser update
// feeding the result register; a byte is accepted whenever the result register
// is empty or being drained. When the receiver stalls, the pending result holds
// and in_stall_o is raised so no further byte enters until the result is taken.
// Config channel: cfg_data_i bit 0 is packet_mode, written on an edge with
// cfg_valid_i high; cfg_ready_o is always high. Write it only while idle.
// Reset: parser returns to idle with its state registers cleared, no result pending,
// and packet_mode cleared to plain header mode.
module socks_address_header_parser_core (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  sap_pkg::in_item_t  in_data_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output sap_pkg::out_item_t out_data_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic               cfg_data_i
);

  logic               out_valid_q, out_valid_d;
  sap_pkg::out_item_t out_q;
  sap_pkg::out_item_t result;
  logic               packet_mode_q;
  logic               accept;
  sap_pkg::step_ctrl_t ctrl;

  assign in_stall_o  = out_valid_q & out_stall_i;
  assign accept      = in_valid_i & ~in_stall_o;
  assign cfg_ready_o = 1'b1;

  assign ctrl.accept      = accept;
  assign ctrl.packet_mode = packet_mode_q;

  sap_parser u_parser (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctrl_i   (ctrl),
    .item_i   (in_data_i),
    .result_o (result)
  );

  assign out_valid_d = accept | (out_valid_q & out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q   <= 1'b0;
      packet_mode_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      if (cfg_valid_i && cfg_ready_o) begin
        packet_mode_q <= cfg_data_i;
      end
    end
  end

  // hold the pending result until taken
  always_ff @(posedge clk_i) begin
    if (accept) begin
      out_q <= result;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// File: hdl/sap_uot_match.sv
// Case-folded domain tail compare against the udp-over-tcp names.
module sap_uot_match (
  input  sap_pkg::kind_e kind_i,
  input  logic [7:0]     domain_len_i,
  input  sap_pkg::tail_t tail_i,
  output sap_pkg::mode_e mode_o
);

  logic hit_v2, hit_v1, hit_sfx;

  assign hit_v2  = (tail_i[22:0] == sap_pkg::NameV2);
  assign hit_v1  = (tail_i[19:0] == sap_pkg::NameV1);
  assign hit_sfx = (tail_i[16:0] == sap_pkg::NameSfx);

  always_comb begin
    mode_o = sap_pkg::ModeTcp;
    if (kind_i == sap_pkg::KindDomain) begin
      if (domain_len_i == sap_pkg::LenV2 && hit_v2) begin
        mode_o = sap_pkg::ModeUotV2;
      end else if (domain_len_i == sap_pkg::LenV1 && hit_v1) begin
        mode_o = sap_pkg::ModeUotV1;
      end else if (domain_len_i >= sap_pkg::LenSfx && hit_sfx) begin
        mode_o = sap_pkg::ModeUotPkt;
      end
    end
  end

endmodule

// File: hdl/sap_parser.sv
// Parser state and per-byte next-state and result logic.
module sap_parser (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  sap_pkg::step_ctrl_t ctrl_i,
  input  sap_pkg::in_item_t   item_i,
  output sap_pkg::out_item_t  result_o
);

  localparam logic [3:0] PhIdle = 4'd0;
  localparam logic [3:0] PhAddr = 4'd1;
  localparam logic [3:0] PhDlen = 4'd2;
  localparam logic [3:0] PhDchr = 4'd3;
  localparam logic [3:0] PhPort = 4'd4;
  localparam logic [3:0] PhPlen = 4'd5;
  localparam logic [3:0] PhPay  = 4'd6;

  logic [3:0]     phase_q, phase_d;
  logic [4:0]     field_q, field_d;
  logic [7:0]     dlen_q, dlen_d;
  logic [7:0]     dcount_q, dcount_d;
  logic [15:0]    port_q, port_d;
  logic [15:0]    plen_q, plen_d;
  logic [15:0]    pcount_q, pcount_d;
  logic [8:0]     hcount_q, hcount_d;
  sap_pkg::kind_e kind_q, kind_d;
  sap_pkg::tail_t tail_q, tail_d;

  logic             kind_ok;
  sap_pkg::kind_e   kind_sel;
  logic             blank;
  logic [7:0]       b;
  logic [7:0]       b_lower;
  sap_pkg::status_e status;
  sap_pkg::role_e   role;
  sap_pkg::mode_e   mode;

  assign b       = item_i.data_byte;
  assign b_lower = (b >= 8'h41 && b <= 8'h5a) ? b + 8'd32 : b;

  always_comb begin
    kind_ok  = 1'b1;
    kind_sel = sap_pkg::KindIpv4;
    if (ctrl_i.packet_mode) begin
      unique case (b)
        sap_pkg::TypePktIpv4:   kind_sel = sap_pkg::KindIpv4;
        sap_pkg::TypePktIpv6:   kind_sel = sap_pkg::KindIpv6;
        sap_pkg::TypePktDomain: kind_sel = sap_pkg::KindDomain;
        default:                kind_ok  = 1'b0;
      endcase
    end else begin
      unique case (b)
        sap_pkg::TypePlainIpv4:   kind_sel = sap_pkg::KindIpv4;
        sap_pkg::TypePlainIpv6:   kind_sel = sap_pkg::KindIpv6;
        sap_pkg::TypePlainDomain: kind_sel = sap_pkg::KindDomain;
        default:                  kind_ok  = 1'b0;
      endcase
    end
  end

  always_comb begin
    phase_d  = phase_q;
    field_d  = field_q;
    dlen_d   = dlen_q;
    dcount_d = dcount_q;
    port_d   = port_q;
    plen_d   = plen_q;
    pcount_d = pcount_q;
    hcount_d = hcount_q;
    kind_d   = kind_q;
    tail_d   = tail_q;
    status   = sap_pkg::StBusy;
    role     = sap_pkg::RoleNone;
    blank    = 1'b0;

    if (item_i.frame_start) begin
      // a type byte always drops whatever message is in progress
      role     = sap_pkg::RoleType;
      field_d  = '0;
      dlen_d   = '0;
      dcount_d = '0;
      port_d   = '0;
      plen_d   = '0;
      pcount_d = '0;
      tail_d   = '0;
      if (!kind_ok) begin
        kind_d   = sap_pkg::KindIpv4;
        hcount_d = '0;
        phase_d  = PhIdle;
        status   = sap_pkg::StBadType;
        blank    = 1'b1;
      end else begin
        kind_d   = kind_sel;
        hcount_d = 9'd1;
        phase_d  = (kind_sel == sap_pkg::KindDomain) ? PhDlen : PhAddr;
      end
    end else begin
      unique case (phase_q)
        PhAddr: begin
          role     = sap_pkg::RoleAddr;
          hcount_d = hcount_q + 9'd1;
          field_d  = field_q + 5'd1;
          if (field_d >= ((kind_q == sap_pkg::KindIpv6) ? 5'd16 : 5'd4)) begin
            phase_d = PhPort;
            field_d = '0;
          end
        end
        PhDlen: begin
          role     = sap_pkg::RoleDlen;
          hcount_d = hcount_q + 9'd1;
          dlen_d   = b;
          dcount_d = '0;
          phase_d  = (b == 8'd0) ? PhPort : PhDchr;
          field_d  = '0;
        end
        PhDchr: begin
          role     = sap_pkg::RoleDchar;
          hcount_d = hcount_q + 9'd1;
          tail_d   = {tail_q[sap_pkg::TailDepth-2:0], b_lower};
          dcount_d = dcount_q + 8'd1;
          if (dcount_d >= dlen_q) begin
            phase_d = PhPort;
            field_d = '0;
          end
        end
        PhPort: begin
          role     = sap_pkg::RolePort;
          hcount_d = hcount_q + 9'd1;
          port_d   = {port_q[7:0], b};
          field_d  = field_q + 5'd1;
          if (field_d >= 5'd2) begin
            if (ctrl_i.packet_mode) begin
              phase_d = PhPlen;
              field_d = '0;
            end else begin
              phase_d = PhIdle;
              status  = sap_pkg::StAddrDone;
            end
          end
        end
        PhPlen: begin
          role    = sap_pkg::RolePlen;
          plen_d  = {plen_q[7:0], b};
          field_d = field_q + 5'd1;
          if (field_d >= 5'd2) begin
            pcount_d = '0;
            if (plen_d == 16'd0) begin
              phase_d = PhIdle;
              status  = sap_pkg::StPktDone;
            end else begin
              phase_d = PhPay;
            end
          end
        end
        PhPay: begin
          role     = sap_pkg::RolePayload;
          pcount_d = pcount_q + 16'd1;
          if (pcount_d >= plen_q) begin
            phase_d = PhIdle;
            status  = sap_pkg::StPktDone;
          end
        end
        default: begin
          // stray byte outside a message
          phase_d = PhIdle;
          status  = sap_pkg::StIgnored;
          blank   = 1'b1;
        end
      endcase
    end
  end

  sap_uot_match u_match (
    .kind_i       (kind_d),
    .domain_len_i (dlen_d),
    .tail_i       (tail_d),
    .mode_o       (mode)
  );

  always_comb begin
    result_o.status    = status;
    result_o.byte_role = role;
    result_o.data_out  = b;
    if (blank) begin
      result_o.addr_kind  = sap_pkg::KindIpv4;
      result_o.port       = '0;
      result_o.mode       = sap_pkg::ModeTcp;
      result_o.header_len = '0;
      result_o.pkt_len    = '0;
    end else begin
      result_o.addr_kind  = kind_d;
      result_o.port       = port_d;
      result_o.mode       = mode;
      result_o.header_len = hcount_d;
      result_o.pkt_len    = plen_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PhIdle;
      field_q  <= '0;
      dlen_q   <= '0;
      dcount_q <= '0;
      port_q   <= '0;
      plen_q   <= '0;
      pcount_q <= '0;
      hcount_q <= '0;
      kind_q   <= sap_pkg::KindIpv4;
      tail_q   <= '0;
    end else if (ctrl_i.accept) begin
      phase_q  <= phase_d;
      field_q  <= field_d;
      dlen_q   <= dlen_d;
      dcount_q <= dcount_d;
      port_q   <= port_d;
      plen_q   <= plen_d;
      pcount_q <= pcount_d;
      hcount_q <= hcount_d;
      kind_q   <= kind_d;
      tail_q   <= tail_d;
    end
  end

endmodule

// File: hdl/sap_checker.sv
// Port-level assertions for the SOCKS address header parser, bound to the top level.
module sap_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_stall_i,
  input sap_pkg::in_item_t  in_data_i,
  input logic               out_valid_i,
  input logic               out_stall_i,
  input sap_pkg::out_item_t out_data_i
);

  // stalled result holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && out_stall_i) |=> (out_valid_i && $stable(out_data_i)))
    else $error("stalled result changed");

  // every accepted request shows its byte on the next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_i) |=>
      (out_valid_i && out_data_i.data_out == $past(in_data_i.data_byte)))
    else $error("accepted byte not passed to result");

  // unknown type blanks the address fields
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && out_data_i.status == sap_pkg::StBadType) |->
      (out_data_i.byte_role == sap_pkg::RoleType && out_data_i.port == 16'd0 &&
       out_data_i.header_len == 9'd0 && out_data_i.mode == sap_pkg::ModeTcp))
    else $error("unknown type result not blank");

  // udp-over-tcp modes only come from a domain
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && out_data_i.mode != sap_pkg::ModeTcp) |->
      (out_data_i.addr_kind == sap_pkg::KindDomain))
    else $error("uot mode without domain address");

endmodule

bind socks_address_header_parser_core sap_checker u_sap_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_i  (in_stall_o),
  .in_data_i   (in_data_i),
  .out_valid_i (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_i  (out_data_o)
);

// File: dv/tb.sv
// Testbench for the SOCKS address header parser: directed table, random messages, scoreboard.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import sap_pkg::*;

  localparam int CycleLimit = 200000;
  localparam int PhaseItems = 240;

  typedef enum logic [2:0] {
    ParseIdle, ParseAddr, ParseDlen, ParseDchr, ParsePort, ParsePlen, ParsePay
  } parse_phase_e;

  typedef struct {
    logic      pinned;
    out_item_t want;
  } pin_note_t;

  typedef struct {
    logic       pm;
    logic       start;
    logic [7:0] data;
    logic       pinned;
    out_item_t  want;
  } script_row_t;

  logic      clk_i;
  logic      rst_ni;
  logic      in_valid_i;
  logic      in_stall_o;
  in_item_t  in_data_i;
  logic      out_valid_o;
  logic      out_stall_i;
  out_item_t out_data_o;
  logic      cfg_valid_i;
  logic      cfg_ready_o;
  logic      cfg_data_i;

  socks_address_header_parser_core DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data_i)
  );

  // Parser state as the scoreboard sees it
  parse_phase_e ph       = ParseIdle;
  int           fld_cnt  = 0;
  logic [7:0]   dom_len  = '0;
  logic [7:0]   dom_cnt  = '0;
  logic [15:0]  port_acc = '0;
  logic [15:0]  plen_acc = '0;
  logic [15:0]  pay_cnt  = '0;
  logic [8:0]   hdr_cnt  = '0;
  kind_e        cur_kind = KindIpv4;
  logic [7:0]   tail [TailDepth] = '{default: 8'h00};  // last entry is the newest char
  logic         pkt_mode = 1'b0;

  out_item_t    want_results [$];
  pin_note_t    pinned_notes [$];
  int           errs = 0;
  int           items_sent = 0;
  logic         stim_pkt_mode = 1'b0;
  logic         calm = 1'b0;
  logic         hold_req = 1'b0;

  script_row_t script [24] = '{
    '{1'b0, 1'b0, 8'h00, 1'b1,
      '{StIgnored, RoleNone, 8'h00, KindIpv4, 16'h0000, ModeTcp, 9'd0, 16'h0000}},
    '{1'b0, 1'b0, 8'hff, 1'b1,
      '{StIgnored, RoleNone, 8'hff, KindIpv4, 16'h0000, ModeTcp, 9'd0, 16'h0000}},
    '{1'b0, 1'b1, 8'hff, 1'b1,
      '{StBadType, RoleType, 8'hff, KindIpv4, 16'h0000, ModeTcp, 9'd0, 16'h0000}},
    '{1'b0, 1'b1, TypePlainIpv4, 1'b0, '0},
    '{1'b0, 1'b0, 8'hff, 1'b0, '0},
    '{1'b0, 1'b0, 8'h00, 1'b0, '0},
    '{1'b0, 1'b0, 8'h80, 1'b0, '0},
    '{1'b0, 1'b0, 8'h7f, 1'b0, '0},
    '{1'b0, 1'b0, 8'hff, 1'b0, '0},
    '{1'b0, 1'b0, 8'hff, 1'b1,
      '{StAddrDone, RolePort, 8'hff, KindIpv4, 16'hffff, ModeTcp, 9'd7, 16'h0000}},
    '{1'b0, 1'b1, TypePlainDomain, 1'b0, '0},
    '{1'b0, 1'b0, 8'h00, 1'b0, '0},
    '{1'b0, 1'b0, 8'h00, 1'b0, '0},
    '{1'b0, 1'b0, 8'h00, 1'b0, '0},
    '{1'b0, 1'b1, TypePlainIpv6, 1'b0, '0},
    '{1'b0, 1'b0, 8'h55, 1'b0, '0},
    // start flag mid-address with a code that plain mode does not know
    '{1'b0, 1'b1, 8'h00, 1'b1,
      '{StBadType, RoleType, 8'h00, KindIpv4, 16'h0000, ModeTcp, 9'd0, 16'h0000}},
    '{1'b1, 1'b1, 8'h03, 1'b1,
      '{StBadType, RoleType, 8'h03, KindIpv4, 16'h0000, ModeTcp, 9'd0, 16'h0000}},
    '{1'b1, 1'b1, TypePktDomain, 1'b0, '0},
    '{1'b1, 1'b0, 8'h00, 1'b0, '0},
    '{1'b1, 1'b0, 8'h12, 1'b0, '0},
    '{1'b1, 1'b0, 8'h34, 1'b0, '0},
    '{1'b1, 1'b0, 8'h00, 1'b0, '0},
    '{1'b1, 1'b0, 8'h00, 1'b1,
      '{StPktDone, RolePlen, 8'h00, KindDomain, 16'h1234, ModeTcp, 9'd4, 16'h0000}}
  };

  function automatic logic tail_ends(string s);
    int n;
    n = s.len();
    for (int i = 0; i < n; i++) begin
      if (tail[TailDepth-n+i] != s[i]) return 1'b0;
    end
    return 1'b1;
  endfunction

  function automatic mode_e uot_mode();
    if (cur_kind != KindDomain) return ModeTcp;
    if (dom_len == 8'd23 && tail_ends("sp.v2.udp-over-tcp.arpa")) return ModeUotV2;
    if (dom_len == 8'd20 && tail_ends("sp.udp-over-tcp.arpa")) return ModeUotV1;
    if (dom_len >= 8'd17 && tail_ends("udp-over-tcp.arpa")) return ModeUotPkt;
    return ModeTcp;
  endfunction

  function automatic out_item_t parse_byte(in_item_t it);
    out_item_t  r;
    logic [7:0] b;
    logic       blank;
    logic       known;
    kind_e      k;
    b = it.data_byte;
    blank = 1'b0;
    known = 1'b1;
    k = KindIpv4;
    r = '0;
    r.status = StBusy;
    r.byte_role = RoleNone;
    r.data_out = b;
    if (it.frame_start) begin
      if (pkt_mode) begin
        if (b == TypePktIpv4) k = KindIpv4;
        else if (b == TypePktIpv6) k = KindIpv6;
        else if (b == TypePktDomain) k = KindDomain;
        else known = 1'b0;
      end else begin
        if (b == TypePlainIpv4) k = KindIpv4;
        else if (b == TypePlainIpv6) k = KindIpv6;
        else if (b == TypePlainDomain) k = KindDomain;
        else known = 1'b0;
      end
      r.byte_role = RoleType;
      fld_cnt = 0;
      dom_len = '0;
      dom_cnt = '0;
      port_acc = '0;
      plen_acc = '0;
      pay_cnt = '0;
      foreach (tail[i]) tail[i] = 8'h00;
      if (!known) begin
        cur_kind = KindIpv4;
        hdr_cnt = '0;
        ph = ParseIdle;
        r.status = StBadType;
        blank = 1'b1;
      end else begin
        cur_kind = k;
        hdr_cnt = 9'd1;
        ph = (k == KindDomain) ? ParseDlen : ParseAddr;
      end
    end else begin
      case (ph)
        ParseAddr: begin
          r.byte_role = RoleAddr;
          hdr_cnt++;
          fld_cnt++;
          if (fld_cnt >= ((cur_kind == KindIpv6) ? 16 : 4)) begin
            ph = ParsePort;
            fld_cnt = 0;
          end
        end
        ParseDlen: begin
          r.byte_role = RoleDlen;
          hdr_cnt++;
          dom_len = b;
          dom_cnt = '0;
          ph = (b == 8'h00) ? ParsePort : ParseDchr;
          fld_cnt = 0;
        end
        ParseDchr: begin
          r.byte_role = RoleDchar;
          hdr_cnt++;
          for (int i = 0; i < TailDepth - 1; i++) tail[i] = tail[i+1];
          tail[TailDepth-1] = (b >= "A" && b <= "Z") ? b + 8'd32 : b;
          dom_cnt++;
          if (dom_cnt >= dom_len) begin
            ph = ParsePort;
            fld_cnt = 0;
          end
        end
        ParsePort: begin
          r.byte_role = RolePort;
          hdr_cnt++;
          port_acc = {port_acc[7:0], b};
          fld_cnt++;
          if (fld_cnt >= 2) begin
            if (pkt_mode) begin
              ph = ParsePlen;
              fld_cnt = 0;
            end else begin
              ph = ParseIdle;
              r.status = StAddrDone;
            end
          end
        end
        ParsePlen: begin
          r.byte_role = RolePlen;
          plen_acc = {plen_acc[7:0], b};
          fld_cnt++;
          if (fld_cnt >= 2) begin
            pay_cnt = '0;
            if (plen_acc == 16'h0000) begin
              ph = ParseIdle;
              r.status = StPktDone;
            end else begin
              ph = ParsePay;
            end
          end
        end
        ParsePay: begin
          r.byte_role = RolePayload;
          pay_cnt++;
          if (pay_cnt >= plen_acc) begin
            ph = ParseIdle;
            r.status = StPktDone;
          end
        end
        default: begin
          ph = ParseIdle;
          r.status = StIgnored;
          r.byte_role = RoleNone;
          blank = 1'b1;
        end
      endcase
    end
    if (!blank) begin
      r.addr_kind = cur_kind;
      r.port = port_acc;
      r.mode = uot_mode();
      r.header_len = hdr_cnt;
      r.pkt_len = plen_acc;
    end
    return r;
  endfunction

  task automatic flag(string what, logic [15:0] want_v, logic [15:0] got_v);
    errs++;
    $display("%0t: %s mismatch, expected %0h, got %0h", $time, what, want_v, got_v);
  endtask

  // Scoreboard: track config writes, predict each accepted request, check each result
  always @(posedge clk_i) begin : scoreboard
    out_item_t want;
    out_item_t got;
    pin_note_t nt;
    if (rst_ni) begin
      if (cfg_valid_i && cfg_ready_o) pkt_mode = cfg_data_i;
      if (in_valid_i && !in_stall_o) begin
        want = parse_byte(in_data_i);
        nt = pinned_notes.pop_front();
        if (nt.pinned) want = nt.want;
        want_results.push_back(want);
      end
      if (out_valid_o && !out_stall_i) begin
        got = out_data_o;
        if (want_results.size() == 0) begin
          errs++;
          $display("%0t: result with nothing expected, expected none, got %h", $time, got);
        end else begin
          want = want_results.pop_front();
          if (got.status !== want.status) flag("status", want.status, got.status);
          if (got.byte_role !== want.byte_role) flag("byte_role", want.byte_role, got.byte_role);
          if (got.data_out !== want.data_out) flag("data_out", want.data_out, got.data_out);
          if (got.addr_kind !== want.addr_kind) flag("addr_kind", want.addr_kind, got.addr_kind);
          if (got.port !== want.port) flag("port", want.port, got.port);
          if (got.mode !== want.mode) flag("mode", want.mode, got.mode);
          if (got.header_len !== want.header_len)
            flag("header_len", want.header_len, got.header_len);
          if (got.pkt_len !== want.pkt_len)
            flag("pkt_len", want.pkt_len, got.pkt_len);
        end
      end
    end
  end

  initial begin : clock_gen
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // Receiver: short random stalls, plus one long hold-off on request
  initial begin : rx_stall
    int burst_left;
    int hold_left;
    burst_left = 0;
    hold_left = 0;
    out_stall_i <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        hold_req = 1'b0;
        hold_left = 80;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall_i <= 1'b1;
      end else if (calm) begin
        out_stall_i <= 1'b0;
      end else if (burst_left > 0) begin
        burst_left--;
        out_stall_i <= 1'b1;
      end else if ($urandom_range(9) == 0) begin
        burst_left = $urandom_range(4);
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  initial begin : watchdog
    repeat (CycleLimit) @(posedge clk_i);
    $display("%0t: cycle limit reached", $time);
    $display("RESULT: ERROR");
    $finish;
  end

  function automatic logic [7:0] type_code(int k);
    if (stim_pkt_mode)
      return (k == 0) ? TypePktIpv4 : (k == 1) ? TypePktIpv6 : TypePktDomain;
    return (k == 0) ? TypePlainIpv4 : (k == 1) ? TypePlainIpv6 : TypePlainDomain;
  endfunction

  task automatic send_byte(logic start, logic [7:0] d, logic pin, out_item_t want);
    pin_note_t nt;
    if (!calm && $urandom_range(7) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk_i);
    end
    nt.pinned = pin;
    nt.want = want;
    pinned_notes.push_back(nt);
    in_valid_i <= 1'b1;
    in_data_i <= '{data_byte: d, frame_start: start};
    do @(posedge clk_i); while (in_stall_o);
    items_sent++;
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (want_results.size() != 0 || pinned_notes.size() != 0);
    repeat (2) @(posedge clk_i);
  endtask

  task automatic set_mode(logic pm);
    cfg_valid_i <= 1'b1;
    cfg_data_i <= pm;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    stim_pkt_mode = pm;
  endtask

  task automatic random_message();
    logic [7:0] msg [$];
    logic [7:0] dq [$];
    string      base;
    int         sel;
    int         kind;
    int         n;
    int         plen;
    logic [7:0] code;
    sel = $urandom_range(99);
    if (sel < 8) begin
      // stray bytes, a few carrying the start flag
      n = $urandom_range(1, 4);
      repeat (n) send_byte($urandom_range(4) == 0, 8'($urandom_range(255)), 1'b0, '0);
    end else if (sel < 12) begin
      do code = 8'($urandom_range(255));
      while (code == type_code(0) || code == type_code(1) || code == type_code(2));
      send_byte(1'b1, code, 1'b0, '0);
      repeat ($urandom_range(2)) send_byte(1'b0, 8'($urandom_range(255)), 1'b0, '0);
    end else begin
      kind = $urandom_range(2);
      msg.push_back(type_code(kind));
      if (kind == 2) begin
        base = "";
        case ($urandom_range(7))
          0: base = "sp.v2.udp-over-tcp.arpa";
          1: base = "sp.udp-over-tcp.arpa";
          2: base = "udp-over-tcp.arpa";
          3: begin
            repeat ($urandom_range(6)) dq.push_back(8'("a" + $urandom_range(25)));
            base = "udp-over-tcp.arpa";
          end
          4: base = $urandom_range(1) ? "sp.v2.udp-over-tcp.arpa" : "sp.udp-over-tcp.arpa";
          5: base = "";
          default: begin
            n = ($urandom_range(15) == 0) ? $urandom_range(24, 255) : $urandom_range(1, 24);
            repeat (n) dq.push_back($urandom_range(1) ? 8'("a" + $urandom_range(25))
                                                      : 8'($urandom_range(255)));
          end
        endcase
        for (int i = 0; i < base.len(); i++) dq.push_back(base[i]);
        // near miss: spoil one char of an exact name
        if (base.len() > 17 && dq.size() == base.len() && $urandom_range(2) == 0)
          dq[$urandom_range(dq.size() - 1)] = 8'($urandom_range(255));
        foreach (dq[i]) begin
          if (dq[i] >= "a" && dq[i] <= "z" && $urandom_range(2) == 0) dq[i] = dq[i] - 8'd32;
        end
        msg.push_back(8'(dq.size()));
        foreach (dq[i]) msg.push_back(dq[i]);
      end else begin
        repeat ((kind == 1) ? 16 : 4) msg.push_back(8'($urandom_range(255)));
      end
      case ($urandom_range(7))
        0: begin msg.push_back(8'h00); msg.push_back(8'h00); end
        1: begin msg.push_back(8'hff); msg.push_back(8'hff); end
        default: begin
          msg.push_back(8'($urandom_range(255)));
          msg.push_back(8'($urandom_range(255)));
        end
      endcase
      if (stim_pkt_mode) begin
        plen = ($urandom_range(5) == 0) ? $urandom_range(300) : $urandom_range(8);
        if (sel < 24 && $urandom_range(1)) plen = $urandom_range(65535);
        msg.push_back(8'(plen >> 8));
        msg.push_back(8'(plen));
        repeat ((plen > 400) ? 10 : plen) msg.push_back(8'($urandom_range(255)));
      end
      // broken message: cut it short, the next start flag drops it
      if (sel < 24) begin
        n = $urandom_range(1, msg.size() - 1);
        while (msg.size() > n) void'(msg.pop_back());
      end
      foreach (msg[i]) send_byte(i == 0, msg[i], 1'b0, '0);
    end
  endtask

  initial begin : stimulus
    int   start_cnt;
    logic held;
    logic paused;
    held = 1'b0;
    paused = 1'b0;
    rst_ni <= 1'b0;
    in_valid_i <= 1'b0;
    in_data_i <= '0;
    cfg_valid_i <= 1'b0;
    cfg_data_i <= 1'b0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    set_mode(1'b0);

    foreach (script[i]) begin
      if (script[i].pm != stim_pkt_mode) begin
        wait_drained();
        set_mode(script[i].pm);
      end
      send_byte(script[i].start, script[i].data, script[i].pinned, script[i].want);
    end

    for (int p = 0; p < 6; p++) begin
      wait_drained();
      set_mode(p[0]);
      if (p == 5) calm = 1'b1;
      start_cnt = items_sent;
      while (items_sent - start_cnt < PhaseItems) begin
        if (p == 1 && !held && items_sent - start_cnt >= 60) begin
          hold_req = 1'b1;
          held = 1'b1;
        end
        // hold the sender until every result is back
        if (p == 3 && !paused && items_sent - start_cnt >= 100) begin
          wait_drained();
          paused = 1'b1;
        end
        random_message();
      end
    end

    wait_drained();
    repeat (4) @(posedge clk_i);
    if (errs == 0 && want_results.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// File: socks_address_header_parser_core.f
hdl/sap_pkg.sv
hdl/sap_uot_match.sv
hdl/sap_parser.sv
hdl/socks_address_header_parser_core.sv
hdl/sap_checker.sv
dv/tb.sv
